// File: design/fifo_page_pool_lookup_unit_defines.svh
// Assertion macros used by the page pool lookup controller (fppl_ctrl).
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef FIFO_PAGE_POOL_LOOKUP_UNIT_DEFINES_SVH
`define FIFO_PAGE_POOL_LOOKUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FPPL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define FPPL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fppl_pkg.sv
// Package for the page pool lookup unit: field widths, tag and result types,
// and the controller state encoding. No dependencies.
package fppl_pkg;

	localparam int unsigned POOL_DEPTH_DEF = 8;
	localparam int unsigned MID_W          = 16;
	localparam int unsigned PIDX_W         = 16;
	localparam int unsigned SLOT_W         = 3;
	localparam int unsigned CAP_W          = 4;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	typedef struct packed {
		logic [MID_W-1:0]  matrix_id;
		logic [PIDX_W-1:0] page_index;
	} tag_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
		logic [MID_W-1:0]  evicted_matrix_id;
		logic [PIDX_W-1:0] evicted_page_index;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_INSERT,
		ST_DONE
	} state_t;

endpackage

// File: design/fppl_ifs.sv
// Valid/ready channel interfaces for the page pool lookup unit:
// request, response and configuration write. Depends on fppl_pkg.
interface fppl_req_if;
	logic                        valid;
	logic                        ready;
	logic [fppl_pkg::MID_W-1:0]  matrix_id;
	logic [fppl_pkg::PIDX_W-1:0] page_index;

	modport source(output valid, output matrix_id, output page_index, input ready);
	modport sink(input valid, input matrix_id, input page_index, output ready);
endinterface

interface fppl_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [fppl_pkg::SLOT_W-1:0] slot;
	logic                        evicted;
	logic [fppl_pkg::MID_W-1:0]  evicted_matrix_id;
	logic [fppl_pkg::PIDX_W-1:0] evicted_page_index;

	modport source(output valid, output hit, output slot, output evicted,
		output evicted_matrix_id, output evicted_page_index, input ready);
	modport sink(input valid, input hit, input slot, input evicted,
		input evicted_matrix_id, input evicted_page_index, output ready);
endinterface

interface fppl_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [fppl_pkg::CAP_W-1:0] pool_capacity;

	modport source(output valid, output pool_capacity, input ready);
	modport sink(input valid, input pool_capacity, output ready);
endinterface

// File: design/fifo_page_pool_lookup_unit.sv
// Page pool lookup unit. Each request beat (matrix_id, page_index) is looked
// up in a fully associative pool of POOL_DEPTH page tags held in a tag RAM with
// registered read. The walk reads one tag per cycle from oldest to newest. A
// hit on the entry k places behind the oldest (k = 0 for the oldest) ends the
// walk there. A miss walks every resident tag and then writes the new tag; with
// an empty pool it goes straight to the write. The result is registered in the
// controller and then loaded into the output register that drives rsp. Once it
// is loaded, the unit returns to idle and can accept the next request. A miss
// inserts the page. Once pool_capacity pages (at least one, at most POOL_DEPTH)
// are resident, it first evicts the oldest one and reports its tag. Hits do not
// change the order. One request is in flight at a time. The next is accepted
// while the previous response waits in the output register. The pool is empty
// after reset with no clearing pass. Write pool_capacity only while no request
// is in flight.
// Depends on fppl_pkg, fppl_ifs, fppl_ctrl and fppl_tag_ram.
module fifo_page_pool_lookup_unit #(
	parameter int unsigned POOL_DEPTH = fppl_pkg::POOL_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fppl_req_if.sink   req,
	fppl_rsp_if.source rsp,
	fppl_cfg_if.sink   cfg
);
	import fppl_pkg::*;

	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

	logic [CAP_W-1:0] cap_q;
	logic             res_valid, res_take, out_valid_q;
	result_t          res, out_q;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	tag_t             ram_wdata, ram_rdata;

	// Capacity register, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.pool_capacity;
		end
	end

	fppl_ctrl #(.POOL_DEPTH(POOL_DEPTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.pool_capacity (cap_q),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	fppl_tag_ram #(.POOL_DEPTH(POOL_DEPTH)) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: load when empty or drained this cycle
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.hit                = out_q.hit;
	assign rsp.slot               = out_q.slot;
	assign rsp.evicted            = out_q.evicted;
	assign rsp.evicted_matrix_id  = out_q.evicted_matrix_id;
	assign rsp.evicted_page_index = out_q.evicted_page_index;

endmodule

// File: design/fppl_tag_ram.sv
// Tag memory of the page pool: one write port, one read port, registered read.
// Depends on fppl_pkg for the tag type.
module fppl_tag_ram #(
	parameter int unsigned POOL_DEPTH = fppl_pkg::POOL_DEPTH_DEF,
	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  fppl_pkg::tag_t wdata,
	input  logic [AW-1:0]  raddr,
	output fppl_pkg::tag_t rdata
);
	import fppl_pkg::*;

	tag_t mem [POOL_DEPTH];

	// Write the inserted tag
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry per cycle, data registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: design/fppl_ctrl.sv
// Lookup controller: walks the resident tags from oldest to newest, inserts on
// a miss with FIFO eviction. Depends on fppl_pkg, fppl_ifs and the macro header.
`include "fifo_page_pool_lookup_unit_defines.svh"

module fppl_ctrl #(
	parameter int unsigned POOL_DEPTH = fppl_pkg::POOL_DEPTH_DEF,
	localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fppl_req_if.sink                   req,
	input  logic [fppl_pkg::CAP_W-1:0] pool_capacity,
	output logic                       res_valid,
	input  logic                       res_take,
	output fppl_pkg::result_t          res,
	output logic                       ram_we,
	output logic [AW-1:0]              ram_waddr,
	output fppl_pkg::tag_t             ram_wdata,
	output logic [AW-1:0]              ram_raddr,
	input  fppl_pkg::tag_t             ram_rdata
);
	import fppl_pkg::*;

	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned EW = (CW > CAP_W) ? CW : CAP_W;

	state_t        state_q, state_d;
	logic [AW-1:0] oldest_q, raddr_q, oldest_inc, raddr_inc, tail;
	logic [CW-1:0] count_q, idx_q;
	logic [SW-1:0] tail_sum;
	logic [EW-1:0] cap_ext, eff_cap;
	tag_t          req_tag_q, first_q;
	result_t       res_q;
	logic          accept, match, last, full;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		if (a == AW'(POOL_DEPTH - 1)) begin
			return '0;
		end
		return a + 1'b1;
	endfunction

	// Ring arithmetic and pool status
	always_comb begin
		oldest_inc = ring_inc(oldest_q);
		raddr_inc  = ring_inc(raddr_q);
		tail_sum   = SW'(oldest_q) + SW'(count_q);
		tail       = (tail_sum >= SW'(POOL_DEPTH)) ? AW'(tail_sum - SW'(POOL_DEPTH))
		                                           : AW'(tail_sum);
		cap_ext    = EW'(pool_capacity);
		if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(POOL_DEPTH)) begin
			eff_cap = EW'(POOL_DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
		full   = (EW'(count_q) >= eff_cap);
		match  = (ram_rdata == req_tag_q);
		last   = (CW'(idx_q + 1'b1) == count_q);
		accept = req.valid && req.ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (count_q == '0) ? ST_INSERT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (last) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory port, handshakes, result
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);
		res       = res_q;
		ram_raddr = (state_q == ST_SEARCH) ? raddr_inc : oldest_q;
		ram_we    = (state_q == ST_INSERT);
		ram_waddr = tail;
		ram_wdata = req_tag_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INSERT) begin
				if (full) begin
					oldest_q <= oldest_inc;
				end else begin
					count_q <= CW'(count_q + 1'b1);
				end
			end
		end
	end

	// Walk position, captured request, oldest tag and result
	always_ff @(posedge clk) begin
		raddr_q <= ram_raddr;
		if (state_q == ST_IDLE) begin
			idx_q <= '0;
		end else if (state_q == ST_SEARCH) begin
			idx_q <= CW'(idx_q + 1'b1);
		end
		if (accept) begin
			req_tag_q.matrix_id  <= req.matrix_id;
			req_tag_q.page_index <= req.page_index;
		end
		if (state_q == ST_SEARCH && idx_q == '0) begin
			first_q <= ram_rdata;
		end
		if (state_q == ST_SEARCH && match) begin
			res_q.hit                <= 1'b1;
			res_q.slot               <= SLOT_W'(raddr_q);
			res_q.evicted            <= 1'b0;
			res_q.evicted_matrix_id  <= '0;
			res_q.evicted_page_index <= '0;
		end else if (state_q == ST_INSERT) begin
			res_q.hit                <= 1'b0;
			res_q.slot               <= SLOT_W'(tail);
			res_q.evicted            <= full;
			res_q.evicted_matrix_id  <= full ? first_q.matrix_id : '0;
			res_q.evicted_page_index <= full ? first_q.page_index : '0;
		end
	end

	`FPPL_ASSERT_NEXT(a_accept_starts_walk, accept,
		(state_q == ST_SEARCH || state_q == ST_INSERT), "accepted beat did not start a lookup")
	`FPPL_ASSERT_NEXT(a_grow_without_evict, (state_q == ST_INSERT && !full),
		(count_q == CW'($past(count_q) + 1'b1)), "insert without eviction did not grow pool")
	`FPPL_ASSERT_NEXT(a_evict_advances_head, (state_q == ST_INSERT && full),
		(oldest_q == $past(oldest_inc) && $stable(count_q)), "eviction did not advance head")
	`FPPL_ASSERT_NOW(a_hit_never_evicts, (res_valid && res.hit),
		(!res.evicted && res.evicted_matrix_id == '0), "hit result reports an eviction")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for fifo_page_pool_lookup_unit: directed table, then random page requests
// checked against an in-bench FIFO page pool predictor. Depends on fppl_pkg and fppl_ifs.
module testbench;
	import fppl_pkg::*;

	localparam int unsigned DEPTH        = POOL_DEPTH_DEF;
	localparam int unsigned HISTORY      = 12;
	localparam int unsigned PHASES       = 9;
	localparam int unsigned PHASE_ITEMS  = 50;
	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned EXPECT_DEPTH = 16;

	typedef struct packed {
		bit               is_cfg;
		logic [CAP_W-1:0] cap;
		tag_t             tag;
		bit               typed;
		result_t          want;
	} directed_row_t;

	localparam result_t NO_CHECK = '0;

	logic clk;
	logic arst_n;

	fppl_req_if req_ch();
	fppl_rsp_if rsp_ch();
	fppl_cfg_if cfg_ch();

	fifo_page_pool_lookup_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	// Predictor state: resident tags in a ring, oldest first
	tag_t             pool_tags [DEPTH];
	int unsigned      oldest_slot;
	int unsigned      resident_cnt;
	logic [CAP_W-1:0] model_capacity;

	// Expected responses in acceptance order
	result_t     expected_ring [EXPECT_DEPTH];
	int unsigned expected_wr;
	int unsigned expected_rd;
	tag_t        recent_tags [HISTORY];
	int unsigned history_fill;
	int unsigned history_pos;
	int unsigned results_taken;
	int unsigned error_count;
	int unsigned cycle_count;
	bit          steady_flow;

	// Extremes after reset, fill to eight, FIFO eviction, hit without reorder,
	// then capacity lowered below the resident count, zero acting as one,
	// and a value above the depth acting as the depth.
	directed_row_t directed_rows [22] = '{
		'{1'b0, 4'd0, '{16'h0000, 16'h0000}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h0000, 16'h0000}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'hFFFF, 16'h0000}, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h0000, 16'hFFFF}, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h0001, 16'h0001}, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h0002, 16'h0002}, 1'b1, '{1'b0, 3'd5, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'hAAAA, 16'h5555}, 1'b1, '{1'b0, 3'd6, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h5555, 16'hAAAA}, 1'b1, '{1'b0, 3'd7, 1'b0, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h1234, 16'h5678}, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 16'h0000}},
		'{1'b0, 4'd0, '{16'h0000, 16'h0000}, 1'b1, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 16'hFFFF}},
		'{1'b0, 4'd0, '{16'hAAAA, 16'h5555}, 1'b1, '{1'b1, 3'd6, 1'b0, 16'h0000, 16'h0000}},
		'{1'b1, 4'd2, '{16'h0000, 16'h0000}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h0007, 16'h0007}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h1234, 16'h5678}, 1'b0, NO_CHECK},
		'{1'b1, 4'd0, '{16'h0000, 16'h0000}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h0008, 16'h0008}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h0008, 16'h0008}, 1'b0, NO_CHECK},
		'{1'b1, 4'd15, '{16'h0000, 16'h0000}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h0009, 16'h0009}, 1'b0, NO_CHECK},
		'{1'b0, 4'd0, '{16'h0000, 16'h0000}, 1'b0, NO_CHECK}
	};

	// Look the page up, update the pool, and return the response it must produce
	function automatic result_t pool_lookup(input tag_t t);
		result_t     r;
		int unsigned cap;
		int unsigned s;
		int unsigned tail;
		r = '0;
		cap = model_capacity;
		if (cap < 1) begin
			cap = 1;
		end
		if (cap > DEPTH) begin
			cap = DEPTH;
		end
		// search oldest to newest; a hit leaves the order alone
		for (int unsigned i = 0; i < resident_cnt; i++) begin
			s = (oldest_slot + i) % DEPTH;
			if (pool_tags[s] == t) begin
				r.hit = 1'b1;
				r.slot = SLOT_W'(s);
				return r;
			end
		end
		tail = (oldest_slot + resident_cnt) % DEPTH;
		if (resident_cnt >= cap) begin
			// eject the oldest entry; the count stays as it is
			r.evicted = 1'b1;
			r.evicted_matrix_id = pool_tags[oldest_slot].matrix_id;
			r.evicted_page_index = pool_tags[oldest_slot].page_index;
			oldest_slot = (oldest_slot + 1) % DEPTH;
		end else begin
			resident_cnt++;
		end
		pool_tags[tail] = t;
		r.slot = SLOT_W'(tail);
		return r;
	endfunction

	// Offer one request beat and queue its expected response once accepted
	task automatic send_request(input tag_t t, input bit typed, input result_t typed_result);
		int unsigned gap;
		result_t     predicted;
		gap = steady_flow ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.matrix_id <= t.matrix_id;
		req_ch.page_index <= t.page_index;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = pool_lookup(t);
		expected_ring[expected_wr % EXPECT_DEPTH] = typed ? typed_result : predicted;
		expected_wr++;
	endtask

	// Drop the request valid and wait until every expected response is back
	task automatic settle_pool();
		req_ch.valid <= 1'b0;
		while (expected_wr != expected_rd) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		settle_pool();
		cfg_ch.pool_capacity <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		model_capacity = value;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predictor reset state
	initial begin
		oldest_slot = 0;
		resident_cnt = 0;
		model_capacity = CAP_RESET;
		expected_wr = 0;
		expected_rd = 0;
		history_fill = 0;
		history_pos = 0;
		results_taken = 0;
		error_count = 0;
		steady_flow = 1'b0;
		foreach (pool_tags[i]) begin
			pool_tags[i] = '0;
		end
	end

	// Request and configuration stimulus
	initial begin : stimulus
		int unsigned      pick;
		tag_t             t;
		logic [CAP_W-1:0] phase_cap [5];
		phase_cap = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4};
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.matrix_id <= '0;
		req_ch.page_index <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.pool_capacity <= CAP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_cfg) begin
				write_capacity(directed_rows[r].cap);
			end else begin
				send_request(directed_rows[r].tag, directed_rows[r].typed, directed_rows[r].want);
			end
		end

		// Random phases: reuse recent pages for hits, a narrow space for churn,
		// and full-range tags for bit coverage
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			write_capacity(phase < 5 ? phase_cap[phase] : CAP_W'($urandom_range(0, 15)));
			steady_flow = (phase == 1 || phase == 6);
			for (int unsigned item = 0; item < PHASE_ITEMS; item++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45 && history_fill != 0) begin
					t = recent_tags[$urandom_range(0, history_fill - 1)];
				end else if (pick < 70) begin
					t.matrix_id = 16'($urandom_range(0, 3));
					t.page_index = 16'($urandom_range(0, 15));
				end else begin
					t.matrix_id = 16'($urandom);
					t.page_index = 16'($urandom);
				end
				recent_tags[history_pos] = t;
				history_pos = (history_pos + 1) % HISTORY;
				if (history_fill < HISTORY) begin
					history_fill++;
				end
				send_request(t, 1'b0, NO_CHECK);
			end
		end

		settle_pool();
		steady_flow = 1'b0;
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_wr == expected_rd) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Response side: random stalls, two long hold-offs to back up the request side
	initial begin : response_sink
		int unsigned stall;
		result_t     got;
		result_t     want;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 9);
			if (results_taken == 150 || results_taken == 330) begin
				stall = 80;
			end
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			results_taken++;
			got.hit = rsp_ch.hit;
			got.slot = rsp_ch.slot;
			got.evicted = rsp_ch.evicted;
			got.evicted_matrix_id = rsp_ch.evicted_matrix_id;
			got.evicted_page_index = rsp_ch.evicted_page_index;
			if (expected_wr == expected_rd) begin
				error_count++;
				$display("%0t: unexpected response beat %0b/%0d/%0b/%h/%h",
					$time, got.hit, got.slot, got.evicted,
					got.evicted_matrix_id, got.evicted_page_index);
			end else begin
				want = expected_ring[expected_rd % EXPECT_DEPTH];
				expected_rd++;
				if (got.hit !== want.hit || got.slot !== want.slot ||
						got.evicted !== want.evicted ||
						got.evicted_matrix_id !== want.evicted_matrix_id ||
						got.evicted_page_index !== want.evicted_page_index) begin
					error_count++;
					$display("%0t: expected %0b/%0d/%0b/%h/%h, got %0b/%0d/%0b/%h/%h",
						$time, want.hit, want.slot, want.evicted,
						want.evicted_matrix_id, want.evicted_page_index,
						got.hit, got.slot, got.evicted,
						got.evicted_matrix_id, got.evicted_page_index);
				end
			end
		end
	end

	// Watchdog: end the run if it hangs
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
